### rtl/core/permutation_unrank_top_defines.svh
// ----------------------------------------------------------------------------
// Permutation unranking assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PERMUTATION_UNRANK_TOP_DEFINES_SVH
`define PERMUTATION_UNRANK_TOP_DEFINES_SVH

// check a consequent in the same cycle as its antecedent
`define PU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check a consequent in the cycle after its antecedent
`define PU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/pu_pkg.sv
// ----------------------------------------------------------------------------
// Permutation unranking package
// Control bundle for the cell row and saturated factorial tables.
// ----------------------------------------------------------------------------
package pu_pkg;

  localparam int unsigned RANK_W = 16;
  localparam int unsigned ELEM_W = 3;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned MSAT_W = RANK_W + 1;

  // factorials, saturated at 2^16 (above any rank)
  localparam logic [MSAT_W-1:0] FACT_SAT [16] = '{
    17'd1, 17'd1, 17'd2, 17'd6, 17'd24, 17'd120, 17'd720, 17'd5040, 17'd40320,
    17'h10000, 17'h10000, 17'h10000, 17'h10000, 17'h10000, 17'h10000, 17'h10000
  };

  typedef struct packed {
    logic             load;
    logic             shift;
    logic [LEN_W-1:0] fidx;
  } pu_ctl_t;

  // k * n!, saturated at 2^16
  function automatic logic [MSAT_W-1:0] msat(input int unsigned k,
                                              input logic [LEN_W-1:0] n);
    logic [MSAT_W+LEN_W-1:0] p;
    p = (MSAT_W+LEN_W)'(k) * (MSAT_W+LEN_W)'(FACT_SAT[n]);
    return (p > (MSAT_W+LEN_W)'(17'h10000)) ? 17'h10000 : p[MSAT_W-1:0];
  endfunction

endpackage

### rtl/core/pu_cell.sv
// ----------------------------------------------------------------------------
// Permutation unranking cell
// Holds one entry of the unused-value list and one multiple of the current
// factorial; compares the running remainder and shifts from its right
// neighbour when an entry at or left of it is removed.
// ----------------------------------------------------------------------------
module pu_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned VW  = 3
) (
  input  logic                          clk,
  input  pu_pkg::pu_ctl_t               ctl_i,
  input  logic [pu_pkg::RANK_W-1:0]     rem_i,
  input  logic                          ge_right_i,
  input  logic [VW-1:0]                 val_right_i,
  output logic                          ge_o,
  output logic                          take_o,
  output logic [VW-1:0]                 val_o,
  output logic [VW-1:0]                 pick_val_o,
  output logic [pu_pkg::RANK_W-1:0]     pick_rem_o
);
  import pu_pkg::*;

  logic [VW-1:0]     val_r, val_nxt;
  logic [MSAT_W-1:0] m_r, m_nxt;
  logic [MSAT_W-1:0] diff;

  always_comb begin
    val_nxt = val_r;
    m_nxt   = m_r;
    if (ctl_i.load) begin
      val_nxt = VW'(IDX);
      m_nxt   = msat(IDX, ctl_i.fidx);
    end else if (ctl_i.shift) begin
      if (!ge_right_i) begin
        val_nxt = val_right_i;
      end
      m_nxt = msat(IDX, ctl_i.fidx);
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    m_r   <= m_nxt;
  end

  assign diff       = {1'b0, rem_i} - m_r;
  assign ge_o       = !diff[MSAT_W-1];
  assign take_o     = ge_o && !ge_right_i;
  assign val_o      = val_r;
  assign pick_val_o = take_o ? val_r : '0;
  assign pick_rem_o = take_o ? diff[RANK_W-1:0] : '0;

endmodule

### rtl/core/permutation_unrank_top.sv
// ----------------------------------------------------------------------------
// Permutation unranking top level
// Turns a rank into the permutation of 0..L-1 with that lexicographic index,
// one element per beat, through a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// channel | ports                                        | handshake
// in      | in_rank                                      | in_valid / in_stall
// out     | out_element, out_last, out_out_of_range      | out_valid / out_stall
// cfg     | cfg_data (perm_length)                       | cfg_valid / cfg_ready
//
// A rank loads the cell row, then gives one element per cycle unless the output stalls,
// as the row picks, subtracts and shifts; an out-of-range rank ends on its first beat.
// Output stall holds the row; a new rank is taken only once the last
// element has been handed to the output register.
// Reset sets perm_length to 5; a length of 0 acts as 1, above MAX_LEN as MAX_LEN.
// ----------------------------------------------------------------------------
`include "permutation_unrank_top_defines.svh"

module permutation_unrank_top #(
  parameter int unsigned MAX_LEN = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pu_pkg::RANK_W-1:0]     in_rank,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pu_pkg::ELEM_W-1:0]     out_element,
  output logic                          out_last,
  output logic                          out_out_of_range,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pu_pkg::LEN_W-1:0]      cfg_data
);
  import pu_pkg::*;

  localparam int unsigned VW = $clog2(MAX_LEN);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  perm_length_r, perm_length_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [RANK_W-1:0] rem_r, rem_nxt;
  logic              oor_r, oor_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ELEM_W-1:0] out_element_r, out_element_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_oor_r, out_oor_nxt;

  logic [CW-1:0]     len_eff;
  logic              accept, adv, finish, oor_in;
  pu_ctl_t           ctl;

  logic              ge    [MAX_LEN+1];
  logic [VW-1:0]     val   [MAX_LEN+1];
  logic [MAX_LEN-1:0] take;
  logic [VW-1:0]     pick_val [MAX_LEN];
  logic [RANK_W-1:0] pick_rem [MAX_LEN];
  logic [VW-1:0]     sel_val;
  logic [RANK_W-1:0] sel_rem;

  assign len_eff = (perm_length_r == '0) ? CW'(1) :
                   (perm_length_r > LEN_W'(MAX_LEN)) ? CW'(MAX_LEN) : CW'(perm_length_r);
  assign oor_in  = {1'b0, in_rank} >= FACT_SAT[LEN_W'(len_eff)];

  assign accept  = in_valid && (state_r == ST_IDLE);
  assign adv     = (state_r == ST_RUN) && (!out_valid_r || !out_stall);
  assign finish  = oor_r || (cnt_r == CW'(1));

  assign ctl.load  = accept;
  assign ctl.shift = adv;
  assign ctl.fidx  = accept ? LEN_W'(len_eff) - LEN_W'(1) : LEN_W'(cnt_r) - LEN_W'(2);

  assign ge[MAX_LEN]  = 1'b0;
  assign val[MAX_LEN] = '0;

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    pu_cell #(
      .IDX (k),
      .VW  (VW)
    ) u_cell (
      .clk         (clk),
      .ctl_i       (ctl),
      .rem_i       (rem_r),
      .ge_right_i  (ge[k+1]),
      .val_right_i (val[k+1]),
      .ge_o        (ge[k]),
      .take_o      (take[k]),
      .val_o       (val[k]),
      .pick_val_o  (pick_val[k]),
      .pick_rem_o  (pick_rem[k])
    );
  end

  always_comb begin
    sel_val = '0;
    sel_rem = '0;
    for (int k = 0; k < MAX_LEN; k++) begin
      sel_val = sel_val | pick_val[k];
      sel_rem = sel_rem | pick_rem[k];
    end
  end

  always_comb begin
    state_nxt       = state_r;
    perm_length_nxt = perm_length_r;
    cnt_nxt         = cnt_r;
    rem_nxt         = rem_r;
    oor_nxt         = oor_r;
    out_valid_nxt   = out_valid_r;
    out_element_nxt = out_element_r;
    out_last_nxt    = out_last_r;
    out_oor_nxt     = out_oor_r;

    if (cfg_valid) begin
      perm_length_nxt = cfg_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
          cnt_nxt   = len_eff;
          rem_nxt   = in_rank;
          oor_nxt   = oor_in;
        end
      end
      ST_RUN: begin
        if (adv) begin
          cnt_nxt = cnt_r - CW'(1);
          rem_nxt = sel_rem;
          if (finish) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (adv) begin
      out_valid_nxt   = 1'b1;
      out_element_nxt = oor_r ? '0 : ELEM_W'(sel_val);
      out_last_nxt    = finish;
      out_oor_nxt     = oor_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      perm_length_r <= LEN_W'(5);
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      perm_length_r <= perm_length_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r         <= cnt_nxt;
    rem_r         <= rem_nxt;
    oor_r         <= oor_nxt;
    out_element_r <= out_element_nxt;
    out_last_r    <= out_last_nxt;
    out_oor_r     <= out_oor_nxt;
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_element      = out_element_r;
  assign out_last         = out_last_r;
  assign out_out_of_range = out_oor_r;

  `PU_ASSERT_SAME(a_oor_is_last, out_valid_r && out_oor_r, out_last_r, "out-of-range beat not last")
  `PU_ASSERT_SAME(a_one_pick, (state_r == ST_RUN) && !oor_r, $onehot(take), "cell row picked other than one entry")
  `PU_ASSERT_SAME(a_cnt_live, (state_r == ST_RUN), cnt_r != '0, "element count exhausted while running")
  `PU_ASSERT_NEXT(a_done_idle, adv && finish, (state_r == ST_IDLE) && out_valid_r && out_last_r, "last beat did not end the rank")

endmodule
